// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker in lbp_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define LBP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define LBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/lbp_pkg.sv
// Types and constants of the 3x3 local binary pattern block.
package lbp_pkg;

	// Configuration
	localparam int CFG_W        = 11;
	localparam int RESET_WIDTH  = 640;
	localparam int RESET_HEIGHT = 480;

	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	// Default frame limits
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	// Field widths
	localparam int PIX_W       = 8;
	localparam int CODE_W      = 8;
	localparam int POS_W       = 10;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 32;

	// Output queue
	localparam int OQ_DEPTH = 3;
	localparam int OQ_PW    = $clog2(OQ_DEPTH);
	localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

	typedef struct packed {
		logic              frame_end;
		logic [POS_W-1:0]  out_row;
		logic [POS_W-1:0]  out_col;
		logic [CODE_W-1:0] lbp_code;
	} result_t;

endpackage

// File: hw/rtl/local_binary_pattern_3x3.sv
// Top level of the streaming 3x3 local binary pattern block.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------------
//  pixels   | in        | s_tvalid/s_tready  | s_tdata: pixel; s_tuser: frame_start
//  codes    | out       | m_tvalid/m_tready  | m_tdata: code,col,row; m_tlast: frame_end
//  config   | in        | cfg_we             | cfg_idx, cfg_wdata
//
// One pixel per cycle while the output queue has room; a code is pushed into the output
// queue in the cycle after its pixel is taken and registered there before it can leave. The
// two line rows share one memory of MAX_WIDTH words, read in the accept cycle and written
// back in the following cycle, with a bypass for a repeated column.
// Reset idles the pipeline, empties the three-entry output queue and sets 640x480;
// the line memory is not cleared. Input stalls only while the queue may overflow.
module local_binary_pattern_3x3
	import lbp_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// pixel stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] pixel
	input  logic                   s_tuser,   // [0] frame_start
	// code stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [7:0] lbp_code, [17:8] out_col,
	                                          // [27:18] out_row, [31:28] zero
	output logic                   m_tlast,   // frame_end
	// configuration writes
	input  logic                   cfg_we,
	input  logic                   cfg_idx,
	input  logic [CFG_W-1:0]       cfg_wdata
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int SWW = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
	localparam int SWH = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;

	// configuration registers
	logic [CFG_W-1:0] width_q, height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(RESET_WIDTH);
			height_q <= CFG_W'(RESET_HEIGHT);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_IMAGE_WIDTH:  width_q  <= cfg_wdata;
				REG_IMAGE_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// saturate frame size to 3..MAX
	logic [SWW-1:0] w_eff, w_ext;
	logic [SWH-1:0] h_eff, h_ext;

	always_comb begin
		w_ext = SWW'(width_q);
		h_ext = SWH'(height_q);
		if (w_ext < SWW'(3))              w_eff = SWW'(3);
		else if (w_ext > SWW'(MAX_WIDTH)) w_eff = SWW'(MAX_WIDTH);
		else                              w_eff = w_ext;
		if (h_ext < SWH'(3))               h_eff = SWH'(3);
		else if (h_ext > SWH'(MAX_HEIGHT)) h_eff = SWH'(MAX_HEIGHT);
		else                               h_eff = h_ext;
	end

	// position of the incoming pixel
	logic [CW-1:0]  col_q, col_a, cur_col, col_m2;
	logic [RW-1:0]  row_q, row_a, cur_row, row_m2;
	logic [SWH-1:0] row_b;
	logic           col_wrap, col_last, row_last, acc;

	assign acc = s_tvalid && s_tready;

	always_comb begin
		col_a    = s_tuser ? '0 : col_q;
		row_a    = s_tuser ? '0 : row_q;
		col_wrap = SWW'(col_a) >= w_eff;
		row_b    = col_wrap ? SWH'(row_a) + SWH'(1) : SWH'(row_a);
		cur_col  = col_wrap ? '0 : col_a;
		cur_row  = (row_b >= h_eff) ? '0 : RW'(row_b);
		col_last = SWW'(cur_col) + SWW'(1) >= w_eff;
		row_last = SWH'(cur_row) + SWH'(1) >= h_eff;
		col_m2   = cur_col - CW'(2);
		row_m2   = cur_row - RW'(2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : cur_row + RW'(1);
			end else begin
				col_q <= cur_col + CW'(1);
				row_q <= cur_row;
			end
		end
	end

	// stage 1 pipeline registers
	logic                 valid_s1, emit_s1, fend_s1;
	logic [CW-1:0]        idx_s1;
	logic [PIX_W-1:0]     bot_s1;
	logic [POS_W-1:0]     ocol_s1, orow_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else         valid_s1 <= acc;
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			idx_s1  <= cur_col;
			bot_s1  <= s_tdata[PIX_W-1:0];
			emit_s1 <= (cur_col >= CW'(2)) && (cur_row >= RW'(2));
			ocol_s1 <= POS_W'(col_m2);
			orow_s1 <= POS_W'(row_m2);
			fend_s1 <= col_last && row_last;
		end
	end

	// line memory: upper row in the high byte, middle row in the low byte
	logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
	logic [2*PIX_W-1:0] rd_s1, fwd_data_s1, rd_word, wr_word;
	logic               fwd_s1;
	logic [PIX_W-1:0]   top, mid;

	always_comb begin
		rd_word = fwd_s1 ? fwd_data_s1 : rd_s1;
		top     = rd_word[2*PIX_W-1:PIX_W];
		mid     = rd_word[PIX_W-1:0];
		wr_word = {mid, bot_s1};
	end

	always_ff @(posedge clk) begin
		if (valid_s1) line_mem[idx_s1] <= wr_word;
		if (acc) begin
			rd_s1       <= line_mem[cur_col];
			fwd_s1      <= valid_s1 && (idx_s1 == cur_col);
			fwd_data_s1 <= wr_word;
		end
	end

	// window: [0..2] two columns back top/mid/bottom, [3..5] one column back
	logic [PIX_W-1:0]  win_q [6];
	logic [CODE_W-1:0] code;
	logic [PIX_W-1:0]  ctr;

	always_comb begin
		ctr  = win_q[4];
		code = {win_q[0] > ctr, win_q[3] > ctr, top > ctr, mid > ctr,
			bot_s1 > ctr, win_q[5] > ctr, win_q[2] > ctr, win_q[1] > ctr};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) win_q[i] <= '0;
		end else if (valid_s1) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top;
			win_q[4] <= mid;
			win_q[5] <= bot_s1;
		end
	end

	// output queue
	result_t          oq_q [OQ_DEPTH];
	result_t          head;
	logic [OQ_PW-1:0] wp_q, rp_q;
	logic [OQ_CW-1:0] cnt_q;
	logic             push, pop;

	assign push     = valid_s1 && emit_s1;
	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = cnt_q != '0;
	assign s_tready = (OQ_CW+1)'(cnt_q) + (OQ_CW+1)'(valid_s1) < (OQ_CW+1)'(OQ_DEPTH);
	assign head     = oq_q[rp_q];
	assign m_tdata  = OUT_TDATA_W'({head.out_row, head.out_col, head.lbp_code});
	assign m_tlast  = head.frame_end;

	always_ff @(posedge clk) begin
		if (push) oq_q[wp_q] <= '{frame_end: fend_s1, out_row: orow_s1,
			out_col: ocol_s1, lbp_code: code};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == OQ_PW'(OQ_DEPTH - 1)) ? '0 : wp_q + OQ_PW'(1);
			if (pop)  rp_q <= (rp_q == OQ_PW'(OQ_DEPTH - 1)) ? '0 : rp_q + OQ_PW'(1);
			cnt_q <= cnt_q + OQ_CW'(push) - OQ_CW'(pop);
		end
	end

endmodule

// File: hw/rtl/lbp_checker.sv
// Port-level checker for the 3x3 local binary pattern block, with its bind.
`include "assert_macros.svh"

module lbp_checker
	import lbp_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic                   m_tlast
);

	// a stalled code request keeps its payload
	`LBP_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled code changed")

	// a new code follows the pixel that completes it through the stage 1 registers and the output queue
	`LBP_ASSERT_IMPL(a_out_origin, clk, arst_n, $rose(m_tvalid), $past(s_tvalid && s_tready, 2), "code without a pixel two cycles earlier")

	// input only stalls while codes are waiting
	`LBP_ASSERT_IMPL(a_stall_cause, clk, arst_n, !s_tready, m_tvalid, "input stalled with empty output")

endmodule

bind local_binary_pattern_3x3 lbp_checker u_lbp_checker (.*);
